// ===== design/ppd_pkg.sv =====
// Package for the preamble/postamble byte deframer.
// Holds the framing markers, the result kind codes and the parser states.
// No dependencies.
package ppd_pkg;

    // Framing markers
    localparam logic [7:0] MARK_START = 8'h11;
    localparam logic [7:0] MARK_END   = 8'h99;

    // Result kinds
    typedef enum logic [2:0] {
        EV_PAYLOAD  = 3'd0,
        EV_EMPTY    = 3'd1,
        EV_JUNK     = 3'd2,
        EV_BADPRE   = 3'd3,
        EV_OVERFLOW = 3'd4,
        EV_BADPOST  = 3'd5
    } ev_kind_t;

    // Parser and readout states, one-hot
    typedef enum logic [5:0] {
        ST_HUNT1    = 6'b000001,
        ST_HUNT2    = 6'b000010,
        ST_RECV     = 6'b000100,
        ST_POST2    = 6'b001000,
        ST_RD_ISSUE = 6'b010000,
        ST_RD_WAIT  = 6'b100000
    } state_t;

endpackage

// ===== design/ppd_if.sv =====
// Valid/ready channel interfaces for the deframer: received bytes in, results out.
// Depends on nothing; payload widths are fixed by the byte and result formats.
interface ppd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface ppd_ev_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_kind;
    logic [7:0] payload_byte;
    logic [6:0] frame_length;
    logic       last;

    modport source (output valid, output event_kind, output payload_byte,
                    output frame_length, output last, input ready);
    modport sink (input valid, input event_kind, input payload_byte,
                  input frame_length, input last, output ready);
endinterface

// ===== design/ppd_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; used for the deframer payload store.
module ppd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/preamble_postamble_deframer.sv =====
// A byte that causes a single result shows it in the output register in the cycle after
// acceptance. Throughput: one byte per cycle while the output register drains and no
// frame is being read out. A completed frame of N payload bytes is read out byte by byte
// (RAM read, then output load), with input held off until the last byte is loaded.
// Reset (async, active low) puts the parse phase in ST_HUNT1 and clears the fill count,
// output valid and preamble_high to zero; the payload store is not cleared and needs none.
module preamble_postamble_deframer #(
    parameter int FRAME_CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [7:0]  cfg_write_data,
    ppd_rx_if.sink      rx,
    ppd_ev_if.source    ev
);

    localparam int AW = (FRAME_CAPACITY > 1) ? $clog2(FRAME_CAPACITY) : 1;
    localparam int CW = $clog2(FRAME_CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(FRAME_CAPACITY);

    ppd_pkg::state_t   state_reg, state_next;
    logic [7:0]        preamble_high_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     ptr_reg, ptr_next;

    logic              out_valid_reg, out_valid_next;
    ppd_pkg::ev_kind_t out_kind_reg, out_kind_next;
    logic [7:0]        out_data_reg, out_data_next;
    logic [6:0]        out_len_reg, out_len_next;
    logic              out_last_reg, out_last_next;

    logic              in_fire;
    logic              out_free;
    logic              ram_we;
    logic              ram_re;
    logic [7:0]        ram_rdata;
    logic              run_last;

    // Payload store; writes happen only while receiving and reads only during readout,
    // so the two never touch the same entry in overlapping cycles
    ppd_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (rx.rx_byte),
        .rd_en   (ram_re),
        .rd_addr (ptr_reg),
        .rd_data (ram_rdata)
    );

    // Take a request in the hunt, receive and postamble states when the output slot frees up
    assign out_free = !out_valid_reg || ev.ready;
    assign rx.ready = out_free && (state_reg == ppd_pkg::ST_HUNT1
                                   || state_reg == ppd_pkg::ST_HUNT2
                                   || state_reg == ppd_pkg::ST_RECV
                                   || state_reg == ppd_pkg::ST_POST2);
    assign in_fire  = rx.valid && rx.ready;
    assign run_last = (CW'(ptr_reg) + CW'(1)) == count_reg;

    // Parser, store access and output register loading
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg && !ev.ready;
        out_kind_next  = out_kind_reg;
        out_data_next  = out_data_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        unique case (state_reg)
            ppd_pkg::ST_HUNT1:
            begin
                if (in_fire)
                begin
                    if (rx.rx_byte == preamble_high_reg)
                    begin
                        state_next = ppd_pkg::ST_HUNT2;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = ppd_pkg::EV_JUNK;
                        out_data_next  = 8'd0;
                        out_len_next   = 7'd0;
                        out_last_next  = 1'b1;
                    end
                end
            end
            ppd_pkg::ST_HUNT2:
            begin
                if (in_fire)
                begin
                    if (rx.rx_byte == ppd_pkg::MARK_START)
                    begin
                        state_next = ppd_pkg::ST_RECV;
                        count_next = '0;
                    end
                    else
                    begin
                        state_next     = ppd_pkg::ST_HUNT1;
                        out_valid_next = 1'b1;
                        out_kind_next  = ppd_pkg::EV_BADPRE;
                        out_data_next  = 8'd0;
                        out_len_next   = 7'd0;
                        out_last_next  = 1'b1;
                    end
                end
            end
            ppd_pkg::ST_RECV:
            begin
                if (in_fire)
                begin
                    if (rx.rx_byte == ppd_pkg::MARK_END)
                    begin
                        state_next = ppd_pkg::ST_POST2;
                    end
                    else if (count_reg < CAP)
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        // Drop the byte on a full store
                        state_next     = ppd_pkg::ST_HUNT1;
                        out_valid_next = 1'b1;
                        out_kind_next  = ppd_pkg::EV_OVERFLOW;
                        out_data_next  = 8'd0;
                        out_len_next   = 7'd0;
                        out_last_next  = 1'b1;
                    end
                end
            end
            ppd_pkg::ST_POST2:
            begin
                if (in_fire)
                begin
                    if (rx.rx_byte != ppd_pkg::MARK_END)
                    begin
                        state_next     = ppd_pkg::ST_HUNT1;
                        out_valid_next = 1'b1;
                        out_kind_next  = ppd_pkg::EV_BADPOST;
                        out_data_next  = 8'd0;
                        out_len_next   = 7'd0;
                        out_last_next  = 1'b1;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next     = ppd_pkg::ST_HUNT1;
                        out_valid_next = 1'b1;
                        out_kind_next  = ppd_pkg::EV_EMPTY;
                        out_data_next  = 8'd0;
                        out_len_next   = 7'd0;
                        out_last_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = ppd_pkg::ST_RD_ISSUE;
                        ptr_next   = '0;
                    end
                end
            end
            ppd_pkg::ST_RD_ISSUE:
            begin
                // Fetch the next stored byte
                ram_re     = 1'b1;
                state_next = ppd_pkg::ST_RD_WAIT;
            end
            ppd_pkg::ST_RD_WAIT:
            begin
                // Load the fetched byte once the output slot is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = ppd_pkg::EV_PAYLOAD;
                    out_data_next  = ram_rdata;
                    out_len_next   = 7'(count_reg);
                    out_last_next  = run_last;
                    if (run_last)
                    begin
                        state_next = ppd_pkg::ST_HUNT1;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + AW'(1);
                        state_next = ppd_pkg::ST_RD_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = ppd_pkg::ST_HUNT1;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ppd_pkg::ST_HUNT1;
            count_reg         <= '0;
            out_valid_reg     <= 1'b0;
            preamble_high_reg <= 8'd0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                preamble_high_reg <= cfg_write_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
        out_len_reg  <= out_len_next;
        out_last_reg <= out_last_next;
    end

    assign ev.valid        = out_valid_reg;
    assign ev.event_kind   = out_kind_reg;
    assign ev.payload_byte = out_data_reg;
    assign ev.frame_length = out_len_reg;
    assign ev.last         = out_last_reg;

endmodule

// ===== design/ppd_checker.sv =====
// Port-level checker for the deframer and its bind to the top level.
// Depends on ppd_pkg for the result kind codes.
module ppd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rx_ready,
    input logic       ev_valid,
    input logic       ev_ready,
    input logic [2:0] event_kind,
    input logic [7:0] payload_byte,
    input logic [6:0] frame_length,
    input logic       last
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && !ev_ready |=> ev_valid && $stable(event_kind) && $stable(payload_byte))
        else $error("stalled result changed or dropped");

    // Zero data and length, and last set, on everything but payload bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && event_kind != ppd_pkg::EV_PAYLOAD |-> payload_byte == 8'd0
            && frame_length == 7'd0 && last)
        else $error("non-payload result carries data or is not last");

    // Payload bytes belong to a frame of nonzero length
    assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && event_kind == ppd_pkg::EV_PAYLOAD |-> frame_length != 7'd0)
        else $error("payload result with zero frame length");

    // Hold off input while a payload run is still being read out
    assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && event_kind == ppd_pkg::EV_PAYLOAD && !last |-> !rx_ready)
        else $error("input open in the middle of a payload run");

endmodule

bind preamble_postamble_deframer ppd_checker u_ppd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_ready     (rx.ready),
    .ev_valid     (ev.valid),
    .ev_ready     (ev.ready),
    .event_kind   (ev.event_kind),
    .payload_byte (ev.payload_byte),
    .frame_length (ev.frame_length),
    .last         (ev.last)
);
